[hdl/gaussian_beam_thin_lens_macros.svh]
// assertion helpers used by the sequencer
`ifndef GAUSSIAN_BEAM_THIN_LENS_MACROS_SVH
`define GAUSSIAN_BEAM_THIN_LENS_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define GBTL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define GBTL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define GBTL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define GBTL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hdl/gbtl_pkg.sv]
package gbtl_pkg;

  // default geometry
  localparam int DEF_WORD_BITS = 40;
  localparam int DEF_FRAC_BITS = 16;

  // pi as a Q2.60 constant
  localparam logic [63:0] PI_Q    = 64'h3243F6A8885A308D;
  localparam int          PI_BITS = 62;
  localparam int          PI_FRAC = 60;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WAVELENGTH = 2'd0,
    CFG_INIT_WAIST = 2'd1,
    CFG_INIT_POS   = 2'd2
  } cfg_idx_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ZERO_F = 2'd1,
    STAT_OVF    = 2'd2
  } status_e;

  // shared arithmetic unit operations
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_WAIT,
    ST_ZR1,
    ST_ZR2,
    ST_ZR3,
    ST_G,
    ST_DD,
    ST_N0,
    ST_N1,
    ST_Q,
    ST_X,
    ST_XD,
    ST_SQ,
    ST_FIN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

[hdl/gaussian_beam_thin_lens.sv]
// channel   dir   handshake                 payload
// cfg       in    cfg_we_i                  cfg_idx_i, cfg_wdata_i
// lens      in    in_valid_i / in_ready_o   restart_i, focal_length_i, lens_position_i
// result    out   out_valid_o / out_ready_i new_waist_o, new_waist_position_o, status_o
//
// every multiply, divide and square root of a lens runs one bit or one root digit per cycle
// on the single shared unit
// errors end the lens early; the next word is taken once the previous lens is finished
// the result register holds one word, so a stalled output holds a finished lens in DONE
// reset is asynchronous active low and loads the register and beam defaults
module gaussian_beam_thin_lens #(
  parameter int WORD_BITS = gbtl_pkg::DEF_WORD_BITS,
  parameter int FRAC_BITS = gbtl_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [WORD_BITS-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 restart_i,
  input  logic [WORD_BITS-1:0] focal_length_i,
  input  logic [WORD_BITS-1:0] lens_position_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-2:0] new_waist_o,
  output logic [WORD_BITS-1:0] new_waist_position_o,
  output logic [1:0]           status_o
);

  localparam int AluW = (4*WORD_BITS + 4 > 2*WORD_BITS + 62) ? 4*WORD_BITS + 4
                                                              : 2*WORD_BITS + 62;
  localparam int LW   = $clog2(AluW + 1);

  logic [WORD_BITS-2:0] wavelength_q, init_waist_q;
  logic [WORD_BITS-1:0] init_pos_q;

  gbtl_pkg::alu_cmd_t alu_cmd;
  gbtl_pkg::alu_sts_t alu_sts;
  logic [AluW-1:0]    alu_a, alu_b, alu_res;
  logic [LW-1:0]      alu_len;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wavelength_q <= {{(WORD_BITS-2){1'b0}}, 1'b1} << FRAC_BITS;
      init_waist_q <= {{(WORD_BITS-2){1'b0}}, 1'b1} << FRAC_BITS;
      init_pos_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbtl_pkg::CFG_WAVELENGTH: wavelength_q <= cfg_wdata_i[WORD_BITS-2:0];
        gbtl_pkg::CFG_INIT_WAIST: init_waist_q <= cfg_wdata_i[WORD_BITS-2:0];
        gbtl_pkg::CFG_INIT_POS:   init_pos_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  gbtl_ctrl #(
    .W    (WORD_BITS),
    .FRAC (FRAC_BITS),
    .A    (AluW)
  ) u_ctrl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .restart_i            (restart_i),
    .focal_length_i       (focal_length_i),
    .lens_position_i      (lens_position_i),
    .wavelength_i         (wavelength_q),
    .init_waist_i         (init_waist_q),
    .init_pos_i           (init_pos_q),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .new_waist_o          (new_waist_o),
    .new_waist_position_o (new_waist_position_o),
    .status_o             (status_o),
    .alu_cmd_o            (alu_cmd),
    .alu_a_o              (alu_a),
    .alu_b_o              (alu_b),
    .alu_len_o            (alu_len),
    .alu_sts_i            (alu_sts),
    .alu_res_i            (alu_res)
  );

  gbtl_alu #(
    .A (AluW)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (alu_cmd),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .len_i  (alu_len),
    .sts_o  (alu_sts),
    .res_o  (alu_res)
  );

endmodule

[hdl/gbtl_alu.sv]
// shared unit: shift-add multiply, restoring divide, digit-by-digit square root
// one add or subtract per cycle over len_i steps
module gbtl_alu #(
  parameter int A = 164
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbtl_pkg::alu_cmd_t  cmd_i,
  input  logic [A-1:0]        a_i,
  input  logic [A-1:0]        b_i,
  input  logic [$clog2(A+1)-1:0] len_i,
  output gbtl_pkg::alu_sts_t  sts_o,
  output logic [A-1:0]        res_o
);

  localparam int LW = $clog2(A+1);

  logic                busy_q, busy_d;
  gbtl_pkg::alu_op_e   op_q, op_d;
  logic [LW-1:0]       cnt_q, cnt_d;
  logic [A:0]          acc_q, acc_d;
  logic [A-1:0]        opa_q, opa_d;
  logic [A-1:0]        opb_q, opb_d;

  logic [A:0]   add_x, add_y, rem_sh;
  logic         add_sub;
  logic [A+1:0] add_sum;
  logic         ge;

  // operand selection for the single adder
  always_comb begin
    rem_sh  = '0;
    add_x   = acc_q;
    add_y   = {1'b0, opa_q};
    add_sub = 1'b0;
    case (op_q)
      gbtl_pkg::OP_DIV: begin
        rem_sh  = {acc_q[A-1:0], opa_q[A-1]};
        add_x   = rem_sh;
        add_y   = {1'b0, opb_q};
        add_sub = 1'b1;
      end
      gbtl_pkg::OP_SQRT: begin
        rem_sh  = {acc_q[A-2:0], opa_q[A-1:A-2]};
        add_x   = rem_sh;
        add_y   = {opb_q[A-2:0], 2'b01};
        add_sub = 1'b1;
      end
      default: begin
        add_x   = acc_q;
        add_y   = {1'b0, opa_q};
        add_sub = 1'b0;
      end
    endcase
    add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (A+2)'(add_sub);
    ge      = add_sum[A+1];
  end

  // step and start
  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      cnt_d  = len_i;
      acc_d  = '0;
      opa_d  = a_i;
      opb_d  = b_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - LW'(1);
      if (cnt_q == LW'(1)) busy_d = 1'b0;
      unique case (op_q)
        gbtl_pkg::OP_MUL: begin
          if (opb_q[0]) acc_d = add_sum[A:0];
          opa_d = {opa_q[A-2:0], 1'b0};
          opb_d = {1'b0, opb_q[A-1:1]};
        end
        gbtl_pkg::OP_DIV: begin
          acc_d = ge ? add_sum[A:0] : rem_sh;
          opa_d = {opa_q[A-2:0], ge};
        end
        gbtl_pkg::OP_SQRT: begin
          acc_d = ge ? add_sum[A:0] : rem_sh;
          opa_d = {opa_q[A-3:0], 2'b00};
          opb_d = {opb_q[A-2:0], ge};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= gbtl_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
  end

  // result select
  always_comb begin
    unique case (op_q)
      gbtl_pkg::OP_DIV:  res_o = opa_q;
      gbtl_pkg::OP_SQRT: res_o = opb_q;
      default:           res_o = acc_q[A-1:0];
    endcase
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && (cnt_q == LW'(1));

endmodule

[hdl/gbtl_ctrl.sv]
`include "gaussian_beam_thin_lens_macros.svh"

// sequencer: walks one lens through the shared unit and keeps the beam
module gbtl_ctrl #(
  parameter int W    = 40,
  parameter int FRAC = 16,
  parameter int A    = 164
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    restart_i,
  input  logic [W-1:0]            focal_length_i,
  input  logic [W-1:0]            lens_position_i,
  input  logic [W-2:0]            wavelength_i,
  input  logic [W-2:0]            init_waist_i,
  input  logic [W-1:0]            init_pos_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [W-2:0]            new_waist_o,
  output logic [W-1:0]            new_waist_position_o,
  output logic [1:0]              status_o,
  output gbtl_pkg::alu_cmd_t      alu_cmd_o,
  output logic [A-1:0]            alu_a_o,
  output logic [A-1:0]            alu_b_o,
  output logic [$clog2(A+1)-1:0]  alu_len_o,
  input  gbtl_pkg::alu_sts_t      alu_sts_i,
  input  logic [A-1:0]            alu_res_i
);

  localparam int LW     = $clog2(A+1);
  localparam int LenZr  = 2*W + 1;
  localparam int LenQ   = 3*W + 1;
  localparam int LenX   = 4*W - 4;
  localparam int Pairs  = 2*W - 2;
  localparam int DW     = 2*W + 1;

  gbtl_pkg::ctrl_state_e state_q, state_d, ret_q, ret_d;
  logic [W-2:0]    beam_w_q, beam_w_d;
  logic [W-1:0]    beam_p_q, beam_p_d;
  logic [W-1:0]    f_q, f_d, p_q, p_d;
  logic [W-1:0]    fmag_q, fmag_d, dmag_q, dmag_d, d_q, d_d, np_q, np_d;
  logic            fneg_q, fneg_d, dneg_q, dneg_d, gneg_q, gneg_d, neg_q, neg_d;
  logic [W:0]      g_q, g_d, gmag_q, gmag_d;
  logic [2*W-3:0]  ww_q, ww_d, zz_q, zz_d;
  logic [DW-1:0]   dd_q, dd_d;
  gbtl_pkg::status_e stat_q, stat_d;
  logic            out_valid_q, out_valid_d;
  logic [W-2:0]    out_w_q, out_w_d;
  logic [W-1:0]    out_p_q, out_p_d;
  gbtl_pkg::status_e out_s_q, out_s_d;

  logic [W:0]      dwide, gwide;
  logic [A-1:0]    tz, num, qt, pext;
  logic [DW-1:0]   rlo, zzx, npos, ndif, nrev, nmag, ddsum;
  logic            nsgn;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    beam_w_d    = beam_w_q;
    beam_p_d    = beam_p_q;
    f_d         = f_q;
    p_d         = p_q;
    fmag_d      = fmag_q;
    fneg_d      = fneg_q;
    d_d         = d_q;
    dmag_d      = dmag_q;
    dneg_d      = dneg_q;
    g_d         = g_q;
    gmag_d      = gmag_q;
    gneg_d      = gneg_q;
    neg_d       = neg_q;
    ww_d        = ww_q;
    zz_d        = zz_q;
    dd_d        = dd_q;
    np_d        = np_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_w_d     = out_w_q;
    out_p_d     = out_p_q;
    out_s_d     = out_s_q;
    in_ready_o  = 1'b0;
    alu_cmd_o.start = 1'b0;
    alu_cmd_o.op    = gbtl_pkg::OP_MUL;
    alu_a_o     = '0;
    alu_b_o     = '0;
    alu_len_o   = '0;

    // datapath helpers: wide adds, slices and sign selects
    dwide = {p_q[W-1], p_q} - {beam_p_q[W-1], beam_p_q};
    gwide = {f_q[W-1], f_q} - {d_q[W-1], d_q};
    tz    = alu_res_i + (A'(wavelength_i) << (gbtl_pkg::PI_FRAC - 1));
    num   = alu_res_i + A'(dd_q >> 1);
    qt    = alu_res_i;
    pext  = {{(A-W){p_q[W-1]}}, p_q};
    rlo   = alu_res_i[DW-1:0];
    zzx   = DW'(zz_q);
    npos  = rlo + zzx;
    ndif  = rlo - zzx;
    nrev  = zzx - rlo;
    ddsum = alu_res_i[DW-1:0] + zzx;
    nsgn  = dneg_q ^ gneg_q;
    nmag  = nsgn ? npos : ((rlo >= zzx) ? ndif : nrev);

    unique case (state_q)
      gbtl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (restart_i) begin
            beam_w_d = init_waist_i;
            beam_p_d = init_pos_i;
          end
          f_d     = focal_length_i;
          p_d     = lens_position_i;
          state_d = gbtl_pkg::ST_CHK;
        end
      end
      // input checks, distance to the waist, then waist squared
      gbtl_pkg::ST_CHK: begin
        fneg_d = f_q[W-1];
        fmag_d = f_q[W-1] ? (~f_q + W'(1)) : f_q;
        if (f_q == '0) begin
          stat_d  = gbtl_pkg::STAT_ZERO_F;
          state_d = gbtl_pkg::ST_DONE;
        end else if (wavelength_i == '0 || dwide[W] != dwide[W-1]) begin
          stat_d  = gbtl_pkg::STAT_OVF;
          state_d = gbtl_pkg::ST_DONE;
        end else begin
          d_d             = dwide[W-1:0];
          alu_cmd_o.start = 1'b1;
          alu_cmd_o.op    = gbtl_pkg::OP_MUL;
          alu_a_o         = A'(beam_w_q);
          alu_b_o         = A'(beam_w_q);
          alu_len_o       = LW'(W - 1);
          ret_d           = gbtl_pkg::ST_ZR1;
          state_d         = gbtl_pkg::ST_WAIT;
        end
      end
      gbtl_pkg::ST_WAIT: begin
        if (alu_sts_i.done) state_d = ret_q;
      end
      // waist squared times pi
      gbtl_pkg::ST_ZR1: begin
        ww_d   = alu_res_i[2*W-3:0];
        g_d    = gwide;
        dneg_d = d_q[W-1];
        dmag_d = d_q[W-1] ? (~d_q + W'(1)) : d_q;
        alu_cmd_o.start = 1'b1;
        alu_cmd_o.op    = gbtl_pkg::OP_MUL;
        alu_a_o         = alu_res_i;
        alu_b_o         = A'(gbtl_pkg::PI_Q);
        alu_len_o       = LW'(gbtl_pkg::PI_BITS);
        ret_d           = gbtl_pkg::ST_ZR2;
        state_d         = gbtl_pkg::ST_WAIT;
      end
      // rounded divide by the wavelength gives the rayleigh range
      gbtl_pkg::ST_ZR2: begin
        gneg_d = g_q[W];
        gmag_d = g_q[W] ? (~g_q + (W+1)'(1)) : g_q;
        alu_cmd_o.start = 1'b1;
        alu_cmd_o.op    = gbtl_pkg::OP_DIV;
        alu_a_o         = (tz >> gbtl_pkg::PI_FRAC) << (A - LenZr);
        alu_b_o         = A'(wavelength_i);
        alu_len_o       = LW'(LenZr);
        ret_d           = gbtl_pkg::ST_ZR3;
        state_d         = gbtl_pkg::ST_WAIT;
      end
      gbtl_pkg::ST_ZR3: begin
        if (alu_res_i[A-1:W-1] != '0) begin
          stat_d  = gbtl_pkg::STAT_OVF;
          state_d = gbtl_pkg::ST_DONE;
        end else begin
          alu_cmd_o.start = 1'b1;
          alu_cmd_o.op    = gbtl_pkg::OP_MUL;
          alu_a_o         = alu_res_i;
          alu_b_o         = alu_res_i;
          alu_len_o       = LW'(W - 1);
          ret_d           = gbtl_pkg::ST_G;
          state_d         = gbtl_pkg::ST_WAIT;
        end
      end
      gbtl_pkg::ST_G: begin
        zz_d = alu_res_i[2*W-3:0];
        alu_cmd_o.start = 1'b1;
        alu_cmd_o.op    = gbtl_pkg::OP_MUL;
        alu_a_o         = A'(gmag_q);
        alu_b_o         = A'(gmag_q);
        alu_len_o       = LW'(W + 1);
        ret_d           = gbtl_pkg::ST_DD;
        state_d         = gbtl_pkg::ST_WAIT;
      end
      // denominator g^2 + zr^2
      gbtl_pkg::ST_DD: begin
        if (ddsum == '0) begin
          stat_d  = gbtl_pkg::STAT_OVF;
          state_d = gbtl_pkg::ST_DONE;
        end else begin
          dd_d            = ddsum;
          alu_cmd_o.start = 1'b1;
          alu_cmd_o.op    = gbtl_pkg::OP_MUL;
          alu_a_o         = A'(dmag_q);
          alu_b_o         = A'(gmag_q);
          alu_len_o       = LW'(W + 1);
          ret_d           = gbtl_pkg::ST_N0;
          state_d         = gbtl_pkg::ST_WAIT;
        end
      end
      // d*g - zr^2 in sign and magnitude, then times f
      gbtl_pkg::ST_N0: begin
        neg_d = (nsgn | (rlo < zzx)) ^ fneg_q;
        alu_cmd_o.start = 1'b1;
        alu_cmd_o.op    = gbtl_pkg::OP_MUL;
        alu_a_o         = A'(nmag);
        alu_b_o         = A'(fmag_q);
        alu_len_o       = LW'(W);
        ret_d           = gbtl_pkg::ST_N1;
        state_d         = gbtl_pkg::ST_WAIT;
      end
      // real part of q', rounded on the magnitude
      gbtl_pkg::ST_N1: begin
        alu_cmd_o.start = 1'b1;
        alu_cmd_o.op    = gbtl_pkg::OP_DIV;
        alu_a_o         = num << (A - LenQ);
        alu_b_o         = A'(dd_q);
        alu_len_o       = LW'(LenQ);
        ret_d           = gbtl_pkg::ST_Q;
        state_d         = gbtl_pkg::ST_WAIT;
      end
      // new position, then f squared
      gbtl_pkg::ST_Q: begin
        if (neg_q) qt = pext + alu_res_i;
        else       qt = pext - alu_res_i;
        if (!((&qt[A-1:W-1]) || (qt[A-1:W-1] == '0))) begin
          stat_d  = gbtl_pkg::STAT_OVF;
          state_d = gbtl_pkg::ST_DONE;
        end else begin
          np_d            = qt[W-1:0];
          alu_cmd_o.start = 1'b1;
          alu_cmd_o.op    = gbtl_pkg::OP_MUL;
          alu_a_o         = A'(fmag_q);
          alu_b_o         = A'(fmag_q);
          alu_len_o       = LW'(W);
          ret_d           = gbtl_pkg::ST_X;
          state_d         = gbtl_pkg::ST_WAIT;
        end
      end
      gbtl_pkg::ST_X: begin
        alu_cmd_o.start = 1'b1;
        alu_cmd_o.op    = gbtl_pkg::OP_MUL;
        alu_a_o         = alu_res_i;
        alu_b_o         = A'(ww_q);
        alu_len_o       = LW'(2*W - 2);
        ret_d           = gbtl_pkg::ST_XD;
        state_d         = gbtl_pkg::ST_WAIT;
      end
      gbtl_pkg::ST_XD: begin
        alu_cmd_o.start = 1'b1;
        alu_cmd_o.op    = gbtl_pkg::OP_DIV;
        alu_a_o         = alu_res_i << (A - LenX);
        alu_b_o         = A'(dd_q);
        alu_len_o       = LW'(LenX);
        ret_d           = gbtl_pkg::ST_SQ;
        state_d         = gbtl_pkg::ST_WAIT;
      end
      gbtl_pkg::ST_SQ: begin
        alu_cmd_o.start = 1'b1;
        alu_cmd_o.op    = gbtl_pkg::OP_SQRT;
        alu_a_o         = alu_res_i << (A - 2*Pairs);
        alu_b_o         = '0;
        alu_len_o       = LW'(Pairs);
        ret_d           = gbtl_pkg::ST_FIN;
        state_d         = gbtl_pkg::ST_WAIT;
      end
      // commit the new beam unless the new waist overflows
      gbtl_pkg::ST_FIN: begin
        if (alu_res_i[A-1:W-1] != '0) begin
          stat_d = gbtl_pkg::STAT_OVF;
        end else begin
          beam_w_d = alu_res_i[W-2:0];
          beam_p_d = np_q;
          stat_d   = gbtl_pkg::STAT_OK;
        end
        state_d = gbtl_pkg::ST_DONE;
      end
      // hand the word to the output register once it is free
      gbtl_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_w_d     = beam_w_q;
          out_p_d     = beam_p_q;
          out_s_d     = stat_q;
          state_d     = gbtl_pkg::ST_IDLE;
        end
      end
      default: state_d = gbtl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbtl_pkg::ST_IDLE;
      ret_q       <= gbtl_pkg::ST_IDLE;
      beam_w_q    <= {{(W-2){1'b0}}, 1'b1} << FRAC;
      beam_p_q    <= '0;
      out_valid_q <= 1'b0;
      stat_q      <= gbtl_pkg::STAT_OK;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      beam_w_q    <= beam_w_d;
      beam_p_q    <= beam_p_d;
      out_valid_q <= out_valid_d;
      stat_q      <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    p_q    <= p_d;
    fmag_q <= fmag_d;
    fneg_q <= fneg_d;
    d_q    <= d_d;
    dmag_q <= dmag_d;
    dneg_q <= dneg_d;
    g_q    <= g_d;
    gmag_q <= gmag_d;
    gneg_q <= gneg_d;
    neg_q  <= neg_d;
    ww_q   <= ww_d;
    zz_q   <= zz_d;
    dd_q   <= dd_d;
    np_q   <= np_d;
    out_w_q <= out_w_d;
    out_p_q <= out_p_d;
    out_s_q <= out_s_d;
  end

  assign out_valid_o          = out_valid_q;
  assign new_waist_o          = out_w_q;
  assign new_waist_position_o = out_p_q;
  assign status_o             = out_s_q;

  // checks
  `GBTL_ASSERT_IMP(a_wait_busy, clk_i, rst_ni, state_q == gbtl_pkg::ST_WAIT, alu_sts_i.busy, "wait state with idle unit")
  `GBTL_ASSERT_IMP(a_start_free, clk_i, rst_ni, alu_cmd_o.start, !alu_sts_i.busy, "unit started while busy")
  `GBTL_ASSERT_NXT(a_accept_chk, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == gbtl_pkg::ST_CHK, "accepted word not checked")
  `GBTL_ASSERT_NXT(a_beam_hold, clk_i, rst_ni, state_q != gbtl_pkg::ST_FIN && state_q != gbtl_pkg::ST_IDLE, $stable(beam_w_q) && $stable(beam_p_q), "beam changed mid lens")

endmodule

[tb/tb_gaussian_beam_thin_lens.sv]
`timescale 1ns / 100ps

module tb_gaussian_beam_thin_lens;

  localparam int WB = 40;
  localparam int FB = 16;
  localparam int WIDE = 320;
  localparam longint LIMIT = 4000000;
  localparam logic [WB-1:0] ONE = WB'(1) << FB;

  typedef logic signed [WIDE-1:0] wide_s;
  typedef logic [WIDE-1:0] wide_u;

  typedef struct {
    logic [WB-2:0]     waist;
    logic [WB-1:0]     pos;
    gbtl_pkg::status_e st;
  } beam_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [WB-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic restart_i = 1'b0;
  logic [WB-1:0] focal_length_i = '0;
  logic [WB-1:0] lens_position_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [WB-2:0] new_waist_o;
  logic [WB-1:0] new_waist_position_o;
  logic [1:0] status_o;

  gaussian_beam_thin_lens dut (.*);

  always #1 clk_i = ~clk_i;

  // shadow of the registers and of the beam
  logic [WB-2:0] wl_q = ONE[WB-2:0];
  logic [WB-2:0] iw_q = ONE[WB-2:0];
  logic [WB-1:0] ip_q = '0;
  logic [WB-2:0] bw_q = ONE[WB-2:0];
  logic [WB-1:0] bp_q = '0;

  beam_word_t beam_words_q[$];
  int fails = 0;
  longint cycles = 0;
  bit idle_en = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  function automatic wide_s sx(logic [WB-1:0] v);
    return {{(WIDE-WB){v[WB-1]}}, v};
  endfunction

  function automatic bit fits_s(wide_s x);
    wide_s lim;
    lim = wide_s'(1) <<< (WB-1);
    return (x >= -lim) && (x < lim);
  endfunction

  function automatic wide_u root_floor(wide_u x);
    wide_u res, cand;
    res = '0;
    for (int i = 100; i >= 0; i--) begin
      cand = res | (wide_u'(1) << i);
      if (cand * cand <= x) res = cand;
    end
    return res;
  endfunction

  // one thin lens on the shadow beam; returns the status
  function automatic gbtl_pkg::status_e lens_transform(logic [WB-1:0] f_raw,
                                                       logic [WB-1:0] p_raw,
                                                       output logic [WB-2:0] nw,
                                                       output logic [WB-1:0] np);
    wide_s f, p, d, g, zr, dd, n, q, t;
    wide_u num, den, mag, w, root;
    bit neg;
    nw = '0;
    np = '0;
    if (f_raw == '0) return gbtl_pkg::STAT_ZERO_F;
    if (wl_q == '0) return gbtl_pkg::STAT_OVF;
    f = sx(f_raw);
    p = sx(p_raw);
    w = wide_u'(bw_q);
    d = p - sx(bp_q);
    if (!fits_s(d)) return gbtl_pkg::STAT_OVF;
    // rayleigh range
    den = wide_u'(wl_q) << gbtl_pkg::PI_FRAC;
    num = w * w * wide_u'(gbtl_pkg::PI_Q) + (den >> 1);
    zr = wide_s'(num / den);
    if (zr >= (wide_s'(1) <<< (WB-1))) return gbtl_pkg::STAT_OVF;
    g = f - d;
    dd = g * g + zr * zr;
    if (dd == 0) return gbtl_pkg::STAT_OVF;
    // real part of q'
    n = f * (d * g - zr * zr);
    neg = n < 0;
    mag = neg ? wide_u'(-n) : wide_u'(n);
    mag = (mag + (wide_u'(dd) >> 1)) / wide_u'(dd);
    q = neg ? -wide_s'(mag) : wide_s'(mag);
    t = p - q;
    if (!fits_s(t)) return gbtl_pkg::STAT_OVF;
    np = t[WB-1:0];
    // new waist
    num = wide_u'(f * f) * w * w / wide_u'(dd);
    root = root_floor(num);
    if (root >= (wide_u'(1) << (WB-1))) return gbtl_pkg::STAT_OVF;
    nw = root[WB-2:0];
    return gbtl_pkg::STAT_OK;
  endfunction

  function automatic void predict_word(logic r, logic [WB-1:0] f, logic [WB-1:0] p);
    beam_word_t e;
    logic [WB-2:0] nw;
    logic [WB-1:0] np;
    gbtl_pkg::status_e st;
    if (r) begin
      bw_q = iw_q;
      bp_q = ip_q;
    end
    st = lens_transform(f, p, nw, np);
    if (st == gbtl_pkg::STAT_OK) begin
      bw_q = nw;
      bp_q = np;
    end
    e.waist = bw_q;
    e.pos = bp_q;
    e.st = st;
    beam_words_q.push_back(e);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (beam_words_q.size() == 0) begin
        $error("unexpected result word");
        fails++;
      end else begin
        beam_word_t e;
        e = beam_words_q.pop_front();
        if (new_waist_o !== e.waist) begin
          $error("new_waist expected %0h actual %0h", e.waist, new_waist_o);
          fails++;
        end
        if (new_waist_position_o !== e.pos) begin
          $error("new_waist_position expected %0h actual %0h", e.pos, new_waist_position_o);
          fails++;
        end
        if (status_o !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status_o);
          fails++;
        end
      end
    end
  end

  // receiver with random idling and long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 4000;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= idle_en ? ($urandom_range(99) >= 20) : 1'b1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** gaussian_beam_thin_lens: FAILED **");
      $finish;
    end
  end

  task automatic send_lens(logic r, logic [WB-1:0] f, logic [WB-1:0] p);
    if (idle_en && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= r;
    focal_length_i <= f;
    lens_position_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_word(r, f, p);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (beam_words_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(gbtl_pkg::cfg_idx_e idx, logic [WB-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gbtl_pkg::CFG_WAVELENGTH: wl_q = val[WB-2:0];
      gbtl_pkg::CFG_INIT_WAIST: iw_q = val[WB-2:0];
      gbtl_pkg::CFG_INIT_POS:   ip_q = val;
      default: ;
    endcase
  endtask

  function automatic logic [WB-1:0] rnd_word();
    return WB'({$urandom, $urandom});
  endfunction

  // a moderate signed length, up to about 2^k units
  function automatic logic [WB-1:0] rnd_len(int k);
    longint v;
    v = longint'({$urandom, $urandom} & ((64'd1 << (k + FB)) - 1)) + 1;
    return WB'($urandom_range(1) ? -v : v);
  endfunction

  task automatic test_directed;
    // zero focal length, extremes of focal length and position
    send_lens(1'b0, '0, '0);
    send_lens(1'b1, ONE * 10, ONE * 5);
    send_lens(1'b0, -(ONE * 10), ONE * 20);
    send_lens(1'b0, {1'b0, {(WB-1){1'b1}}}, '0);
    send_lens(1'b1, {1'b1, {(WB-1){1'b0}}}, '0);
    send_lens(1'b1, ONE, {1'b0, {(WB-1){1'b1}}});
    send_lens(1'b0, ONE, {1'b1, {(WB-1){1'b0}}});
    send_lens(1'b1, '1, '1);
    send_lens(1'b1, 40'd1, ONE * 3);
    // restart together with an error
    send_lens(1'b1, '0, ONE);
    send_lens(1'b0, ONE * 2, ONE * 2);
    drain();
  endtask

  task automatic test_config_extremes;
    // tiny waist and long wavelength make the rayleigh range round to zero,
    // then a lens one focal length from the waist is singular
    write_reg(gbtl_pkg::CFG_WAVELENGTH, {1'b0, {(WB-1){1'b1}}});
    write_reg(gbtl_pkg::CFG_INIT_WAIST, 40'd1);
    write_reg(gbtl_pkg::CFG_INIT_POS, ONE * 7);
    send_lens(1'b1, ONE * 3, ONE * 10);
    send_lens(1'b1, ONE * 3, ONE * 11);
    send_lens(1'b1, -(ONE * 2), ONE * 5);
    drain();
    // huge waist with the shortest wavelength: rayleigh range too large
    write_reg(gbtl_pkg::CFG_WAVELENGTH, 40'd1);
    write_reg(gbtl_pkg::CFG_INIT_WAIST, {1'b0, {(WB-1){1'b1}}});
    write_reg(gbtl_pkg::CFG_INIT_POS, {1'b1, {(WB-1){1'b0}}});
    send_lens(1'b1, ONE, ONE);
    send_lens(1'b1, ONE, {1'b0, {(WB-1){1'b1}}});
    drain();
    write_reg(gbtl_pkg::CFG_INIT_POS, {1'b0, {(WB-1){1'b1}}});
    send_lens(1'b1, ONE * 4, {1'b1, {(WB-1){1'b0}}});
    send_lens(1'b1, -ONE, '0);
    drain();
  endtask

  task automatic random_lenses(int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 70)
        send_lens($urandom_range(3) == 0, rnd_len($urandom_range(1, 12)),
                  bp_q + rnd_len($urandom_range(1, 12)));
      else if (kind < 88)
        send_lens(1'($urandom_range(1)), rnd_word(), rnd_word());
      else if (kind < 94)
        send_lens(1'($urandom_range(1)), '0, rnd_word());
      else
        send_lens(1'b1, rnd_len($urandom_range(0, 22)), rnd_word());
    end
  endtask

  task automatic test_random;
    write_reg(gbtl_pkg::CFG_WAVELENGTH, ONE / 2);
    write_reg(gbtl_pkg::CFG_INIT_WAIST, ONE * 2);
    write_reg(gbtl_pkg::CFG_INIT_POS, -(ONE * 3));
    idle_en = 1'b0;
    random_lenses(60);
    idle_en = 1'b1;
    random_lenses(200);
    drain();
    write_reg(gbtl_pkg::CFG_WAVELENGTH, WB'(rnd_word() & ((64'd1 << 24) - 1) | 1));
    write_reg(gbtl_pkg::CFG_INIT_WAIST, WB'(rnd_word() & ((64'd1 << 22) - 1) | 1));
    write_reg(gbtl_pkg::CFG_INIT_POS, rnd_word());
    random_lenses(150);
    drain();
    write_reg(gbtl_pkg::CFG_WAVELENGTH, rnd_word() | WB'(1));
    write_reg(gbtl_pkg::CFG_INIT_WAIST, rnd_word() | WB'(1));
    random_lenses(80);
    drain();
  endtask

  task automatic test_backpressure;
    write_reg(gbtl_pkg::CFG_WAVELENGTH, ONE);
    write_reg(gbtl_pkg::CFG_INIT_WAIST, ONE);
    write_reg(gbtl_pkg::CFG_INIT_POS, '0);
    hold_req = 1'b1;
    random_lenses(12);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    if (fails == 0 && beam_words_q.size() == 0)
      $display("** gaussian_beam_thin_lens: PASSED **");
    else
      $display("** gaussian_beam_thin_lens: FAILED **");
    $finish;
  end

endmodule
